/* hw/rtl/icl_pkg.sv */
`default_nettype none
package icl_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int CHAR_W        = 8;

    typedef enum logic [3:0] {
        F_INS_BACK  = 4'd0,
        F_INS_FRONT = 4'd1,
        F_INS_AT    = 4'd2,
        F_RM_FRONT  = 4'd3,
        F_RM_BACK   = 4'd4,
        F_RM_AT     = 4'd5,
        F_REPLACE   = 4'd6,
        F_READ      = 4'd7,
        F_CLEAR     = 4'd8
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // per-cycle command broadcast along the cell row
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_RM   = 2'd2,
        CELL_WR   = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [CHAR_W-1:0]  ch;
    } t_cell_cmd;

endpackage
`default_nettype wire

/* hw/rtl/indexed_char_list.sv */
// Indexed character list built as a row of shifting cells.
// The cell row updates when a request is accepted; the result is read from the updated
// row into the output registers once the output is free, and o_stall holds off new
// requests until then.
// Reset: synchronous, active low; the list becomes empty, no result pending.
// Cell contents are not reset; only entries below the count are ever read.
`default_nettype none
module indexed_char_list
    import icl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [3:0]  i_func,
    input  wire logic [7:0]  i_char_value,
    input  wire logic [6:0]  i_position,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_read_char,
    output logic [1:0]       o_status,
    output logic [6:0]       o_count,
    output logic             o_is_empty,
    output logic [7:0]       o_first_char,
    output logic [7:0]       o_last_char
);

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic              accept;
    logic              load;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_busy;
    t_status           r_status;
    t_status           n_status;
    logic              r_rd_en;
    logic              n_rd_en;
    logic [IW-1:0]     r_rd_at;

    logic [CMPW-1:0]   pos_w;
    logic [CMPW-1:0]   cnt_w;
    logic [CMPW-1:0]   tgt;
    t_cell_cmd         cmd;
    t_cell_op          dec_op;
    logic [IW-1:0]     at;

    logic [CHAR_W-1:0] cell_q [DEPTH];
    logic [CHAR_W-1:0] rd_sel;
    logic [CHAR_W-1:0] last_sel;
    logic [IW-1:0]     last_at;

    logic              r_out_valid;
    logic [7:0]        r_out_rd;
    t_status           r_out_status;
    logic [6:0]        r_out_count;
    logic              r_out_empty;
    logic [7:0]        r_out_first;
    logic [7:0]        r_out_last;

    assign o_stall = r_busy;
    assign accept  = i_valid && !r_busy;
    assign load    = r_busy && (!r_out_valid || !i_stall);

    assign pos_w = CMPW'(i_position);
    assign cnt_w = CMPW'(r_count);

    // request decode against the current count
    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_rd_en  = 1'b0;
        dec_op   = CELL_HOLD;
        tgt      = '0;
        unique case (i_func) inside
            F_INS_BACK, F_INS_FRONT, F_INS_AT: begin
                if (i_func == F_INS_BACK) begin
                    tgt = cnt_w;
                end else if (i_func == F_INS_AT) begin
                    tgt = pos_w;
                end
                if (r_count == FULL_CNT) begin
                    n_status = ST_FULL;
                end else if (tgt > cnt_w) begin
                    n_status = ST_RANGE;
                end else begin
                    dec_op  = CELL_INS;
                    n_count = r_count + CW'(1);
                end
            end
            F_RM_FRONT, F_RM_BACK: begin
                if (i_func == F_RM_BACK) begin
                    tgt = cnt_w - CMPW'(1);
                end
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    dec_op  = CELL_RM;
                    n_count = r_count - CW'(1);
                end
            end
            F_RM_AT: begin
                tgt = pos_w;
                if (pos_w >= cnt_w) begin
                    n_status = ST_RANGE;
                end else begin
                    dec_op  = CELL_RM;
                    n_count = r_count - CW'(1);
                end
            end
            F_REPLACE: begin
                tgt = pos_w;
                if (pos_w >= cnt_w) begin
                    n_status = ST_RANGE;
                end else begin
                    dec_op = CELL_WR;
                end
            end
            F_READ: begin
                tgt = pos_w;
                if (pos_w >= cnt_w) begin
                    n_status = ST_RANGE;
                end else begin
                    n_rd_en = 1'b1;
                end
            end
            F_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign at     = tgt[IW-1:0];
    assign cmd.op = accept ? dec_op : CELL_HOLD;
    assign cmd.ch = i_char_value;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [CHAR_W-1:0] lower;
            logic [CHAR_W-1:0] upper;
            if (gi == 0) begin : g_first
                assign lower = '0;
            end else begin : g_mid_lo
                assign lower = cell_q[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign upper = cell_q[gi];
            end else begin : g_mid_hi
                assign upper = cell_q[gi+1];
            end
            icl_cell #(
                .IW  (IW),
                .IDX (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_cmd   (cmd),
                .i_at    (at),
                .i_lower (lower),
                .i_upper (upper),
                .o_char  (cell_q[gi])
            );
        end
    endgenerate

    assign last_at = r_count[IW-1:0] - IW'(1);

    // each cell's value is taken only when its index is selected; OR the row together
    always_comb begin
        rd_sel   = '0;
        last_sel = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (r_rd_at == IW'(k)) begin
                rd_sel = rd_sel | cell_q[k];
            end
            if (last_at == IW'(k)) begin
                last_sel = last_sel | cell_q[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_busy  <= 1'b1;
            end else if (load) begin
                r_busy  <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_rd_en  <= n_rd_en;
            r_rd_at  <= at;
        end
        if (load) begin
            r_out_rd     <= r_rd_en ? rd_sel : '0;
            r_out_status <= r_status;
            r_out_count  <= cnt_w[6:0];
            r_out_empty  <= (r_count == '0);
            r_out_first  <= (r_count == '0) ? '0 : cell_q[0];
            r_out_last   <= (r_count == '0) ? '0 : last_sel;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_char  = r_out_rd;
    assign o_status     = r_out_status;
    assign o_count      = r_out_count;
    assign o_is_empty   = r_out_empty;
    assign o_first_char = r_out_first;
    assign o_last_char  = r_out_last;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("count above depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_busy)
        else $error("accepted request not held busy");

    a_busy_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !load) |=> (r_busy && $stable(r_count)))
        else $error("pending request lost or count changed");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> o_valid)
        else $error("result not presented after load");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> (o_first_char == '0 && o_last_char == '0))
        else $error("empty list shows characters");
`endif

endmodule
`default_nettype wire

/* hw/rtl/icl_cell.sv */
`default_nettype none
module icl_cell
    import icl_pkg::*;
#(
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  wire logic              i_clk,
    input  wire t_cell_cmd         i_cmd,
    input  wire logic [IW-1:0]     i_at,
    input  wire logic [CHAR_W-1:0] i_lower,
    input  wire logic [CHAR_W-1:0] i_upper,
    output logic [CHAR_W-1:0]      o_char
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [CHAR_W-1:0] r_char;
    logic [CHAR_W-1:0] n_char;

    always_comb begin
        n_char = r_char;
        case (i_cmd.op)
            CELL_INS: begin
                // entries at and above the insert point move up one place
                if (MY_IDX > i_at) begin
                    n_char = i_lower;
                end else if (MY_IDX == i_at) begin
                    n_char = i_cmd.ch;
                end
            end
            CELL_RM: begin
                if (MY_IDX >= i_at) begin
                    n_char = i_upper;
                end
            end
            CELL_WR: begin
                if (MY_IDX == i_at) begin
                    n_char = i_cmd.ch;
                end
            end
            default: n_char = r_char;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
    end

    assign o_char = r_char;

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
    import icl_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int GEN_ITEMS = 1450;
    localparam logic [3:0] FUNC_UNUSED_LO = 4'd9;
    localparam logic [3:0] FUNC_UNUSED_HI = 4'd15;

    typedef struct {
        logic [3:0] func;
        logic [7:0] ch;
        logic [6:0] pos;
        int         gap;
        bit         drain;
    } t_list_req;

    typedef struct {
        logic [7:0] read_char;
        t_status    status;
        logic [6:0] count;
        logic       is_empty;
        logic [7:0] first_char;
        logic [7:0] last_char;
    } t_list_view;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [3:0] i_func = '0;
    logic [7:0] i_char_value = '0;
    logic [6:0] i_position = '0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_read_char;
    logic [1:0] o_status;
    logic [6:0] o_count;
    logic       o_is_empty;
    logic [7:0] o_first_char;
    logic [7:0] o_last_char;

    indexed_char_list dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_char_value (i_char_value),
        .i_position   (i_position),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_char  (o_read_char),
        .o_status     (o_status),
        .o_count      (o_count),
        .o_is_empty   (o_is_empty),
        .o_first_char (o_first_char),
        .o_last_char  (o_last_char)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_list_req  cmd_backlog[$];
    t_list_view expected_views[$];
    t_list_req  cur_req;
    int         idle_cycles;
    int         n_sent;
    int         n_checked;
    int         n_err;
    int         seen_status[4];

    // shadow list, updated once per accepted request
    logic [7:0] model_chars[DEPTH];
    int         model_len;

    // stimulus bookkeeping: length the list will have once the backlog is applied
    int         gen_len;
    int         gen_total;
    bit         gen_calm;

    function automatic t_status insert_char(int at, logic [7:0] ch);
        if (model_len >= DEPTH)
            return ST_FULL;
        if (at > model_len)
            return ST_RANGE;
        for (int i = model_len; i > at; i--)
            model_chars[i] = model_chars[i - 1];
        model_chars[at] = ch;
        model_len++;
        return ST_OK;
    endfunction

    function automatic t_status drop_char(int at);
        if (at >= model_len)
            return ST_RANGE;
        for (int i = at; i + 1 < model_len; i++)
            model_chars[i] = model_chars[i + 1];
        model_len--;
        return ST_OK;
    endfunction

    function automatic t_list_view apply_list_op(t_list_req r);
        t_list_view v;
        v.read_char = '0;
        v.status = ST_OK;
        case (r.func)
            F_INS_BACK:  v.status = insert_char(model_len, r.ch);
            F_INS_FRONT: v.status = insert_char(0, r.ch);
            F_INS_AT:    v.status = insert_char(int'(r.pos), r.ch);
            F_RM_FRONT:  v.status = (model_len == 0) ? ST_EMPTY : drop_char(0);
            F_RM_BACK:   v.status = (model_len == 0) ? ST_EMPTY : drop_char(model_len - 1);
            F_RM_AT:     v.status = drop_char(int'(r.pos));
            F_REPLACE: begin
                if (int'(r.pos) >= model_len)
                    v.status = ST_RANGE;
                else
                    model_chars[r.pos] = r.ch;
            end
            F_READ: begin
                if (int'(r.pos) >= model_len)
                    v.status = ST_RANGE;
                else
                    v.read_char = model_chars[r.pos];
            end
            F_CLEAR:     model_len = 0;
            default: ;
        endcase
        v.count = 7'(model_len);
        v.is_empty = (model_len == 0);
        v.first_char = (model_len == 0) ? 8'h00 : model_chars[0];
        v.last_char = (model_len == 0) ? 8'h00 : model_chars[model_len - 1];
        return v;
    endfunction

    task automatic add_req(logic [3:0] f, logic [7:0] ch, logic [6:0] pos, bit drain);
        t_list_req r;
        r.func = f;
        r.ch = ch;
        r.pos = pos;
        r.gap = gen_calm ? 0 : $urandom_range(0, 11);
        r.drain = drain;
        cmd_backlog.push_back(r);
        gen_total++;
        case (f)
            F_INS_BACK, F_INS_FRONT: if (gen_len < DEPTH) gen_len++;
            F_INS_AT:                if (gen_len < DEPTH && int'(pos) <= gen_len) gen_len++;
            F_RM_FRONT, F_RM_BACK:   if (gen_len > 0) gen_len--;
            F_RM_AT:                 if (int'(pos) < gen_len) gen_len--;
            F_CLEAR:                 gen_len = 0;
            default: ;
        endcase
    endtask

    // mostly in range for the list as it will be, sometimes anywhere
    function automatic logic [6:0] pick_pos(bit for_insert);
        if ($urandom_range(0, 9) == 0)
            return 7'($urandom_range(0, 127));
        if (for_insert)
            return 7'($urandom_range(0, gen_len));
        return (gen_len == 0) ? 7'd0 : 7'($urandom_range(0, gen_len - 1));
    endfunction

    // request side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            idle_cycles = 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_views.push_back(apply_list_op(cur_req));
                n_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (cmd_backlog.size() != 0 && idle_cycles >= cmd_backlog[0].gap &&
                        !(cmd_backlog[0].drain && expected_views.size() != 0)) begin
                    cur_req = cmd_backlog.pop_front();
                    i_func <= cur_req.func;
                    i_char_value <= cur_req.ch;
                    i_position <= cur_req.pos;
                    i_valid <= 1'b1;
                    idle_cycles = 0;
                end else begin
                    i_valid <= 1'b0;
                    idle_cycles++;
                end
            end
        end
    end

    // result side
    int  rx_hold;
    bit  rx_calm;
    t_list_view want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_hold = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_views.size() == 0) begin
                    $error("result with no request outstanding");
                    n_err++;
                end else begin
                    want = expected_views.pop_front();
                    if (o_read_char !== want.read_char) begin
                        $error("read_char: expected %0h, got %0h", want.read_char, o_read_char);
                        n_err++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        n_err++;
                    end
                    if (o_count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, o_count);
                        n_err++;
                    end
                    if (o_is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0b, got %0b", want.is_empty, o_is_empty);
                        n_err++;
                    end
                    if (o_first_char !== want.first_char) begin
                        $error("first_char: expected %0h, got %0h",
                               want.first_char, o_first_char);
                        n_err++;
                    end
                    if (o_last_char !== want.last_char) begin
                        $error("last_char: expected %0h, got %0h", want.last_char, o_last_char);
                        n_err++;
                    end
                    seen_status[want.status]++;
                end
                n_checked++;
                if (n_checked % 100 == 0)
                    rx_calm = ($urandom_range(0, 2) == 0);
                rx_hold = rx_calm ? 0 : $urandom_range(0, 11);
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            i_stall <= (rx_hold > 0);
        end
    end

    initial begin
        #400000;
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        t_func ins_ops[3] = '{F_INS_BACK, F_INS_FRONT, F_INS_AT};
        t_func rm_ops[3] = '{F_RM_FRONT, F_RM_BACK, F_RM_AT};
        t_func look_ops[2] = '{F_READ, F_REPLACE};
        t_func f;
        int mode;
        int len;
        bit drain;

        // directed: empty-list corner cases, then a small list
        add_req(F_RM_FRONT, 8'h00, 7'd0, 1'b0);
        add_req(F_RM_BACK, 8'h00, 7'd0, 1'b0);
        add_req(F_RM_AT, 8'h00, 7'd0, 1'b0);
        add_req(F_READ, 8'h00, 7'd0, 1'b0);
        add_req(F_REPLACE, 8'hff, 7'd0, 1'b0);
        add_req(F_INS_AT, 8'h11, 7'd1, 1'b0);
        add_req(F_INS_AT, 8'h41, 7'd0, 1'b0);
        add_req(F_INS_BACK, 8'hff, 7'd127, 1'b0);
        add_req(F_INS_FRONT, 8'h00, 7'd0, 1'b0);
        add_req(F_INS_AT, 8'h80, 7'd3, 1'b0);     // index equal to count appends
        add_req(F_INS_AT, 8'h7f, 7'd1, 1'b0);
        add_req(F_READ, 8'h00, 7'd0, 1'b0);
        add_req(F_READ, 8'hff, 7'd4, 1'b0);
        add_req(F_READ, 8'h00, 7'd127, 1'b0);
        add_req(F_REPLACE, 8'h55, 7'd4, 1'b0);
        add_req(F_REPLACE, 8'haa, 7'd5, 1'b0);
        add_req(F_RM_AT, 8'h00, 7'd2, 1'b0);
        add_req(F_RM_AT, 8'h00, 7'd64, 1'b0);
        add_req(FUNC_UNUSED_LO, 8'hff, 7'd127, 1'b1);
        add_req(FUNC_UNUSED_HI, 8'h00, 7'd0, 1'b0);
        add_req(F_RM_FRONT, 8'h00, 7'd0, 1'b0);
        add_req(F_RM_BACK, 8'h00, 7'd0, 1'b0);
        add_req(F_CLEAR, 8'h00, 7'd0, 1'b0);
        add_req(F_CLEAR, 8'h00, 7'd0, 1'b0);

        // random phases: fill to full, grow, shrink, mixed, noise
        while (gen_total < GEN_ITEMS) begin
            mode = $urandom_range(0, 9);
            gen_calm = ($urandom_range(0, 3) == 0);
            drain = ($urandom_range(0, 5) == 0);
            len = (mode == 0) ? DEPTH - gen_len + $urandom_range(1, 4) : $urandom_range(20, 80);
            repeat (len) begin
                case (mode)
                    0: begin
                        f = ins_ops[$urandom_range(0, 2)];
                        add_req(f, 8'($urandom()), pick_pos(1'b1), drain);
                    end
                    1, 2, 3: begin
                        if ($urandom_range(0, 3) != 0) begin
                            f = ins_ops[$urandom_range(0, 2)];
                            add_req(f, 8'($urandom()), pick_pos(1'b1), drain);
                        end else begin
                            f = look_ops[$urandom_range(0, 1)];
                            add_req(f, 8'($urandom()), pick_pos(1'b0), drain);
                        end
                    end
                    4, 5, 6: begin
                        if ($urandom_range(0, 3) != 0)
                            f = rm_ops[$urandom_range(0, 2)];
                        else
                            f = look_ops[$urandom_range(0, 1)];
                        add_req(f, 8'($urandom()), pick_pos(1'b0), drain);
                    end
                    7, 8: begin
                        f = t_func'($urandom_range(F_INS_BACK, F_REPLACE + 1));
                        if ($urandom_range(0, 39) == 0)
                            f = F_CLEAR;
                        add_req(f, 8'($urandom()), pick_pos(f <= F_INS_AT), drain);
                    end
                    default:
                        add_req(4'($urandom()), 8'($urandom()), 7'($urandom()), drain);
                endcase
                drain = 1'b0;
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || i_valid || expected_views.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked", n_sent, n_checked);
        $display("status seen: ok %0d, empty %0d, out of range %0d, full %0d",
                 seen_status[ST_OK], seen_status[ST_EMPTY],
                 seen_status[ST_RANGE], seen_status[ST_FULL]);
        if (n_err == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/icl_pkg.sv
hw/rtl/icl_cell.sv
hw/rtl/indexed_char_list.sv
tb/tb.sv
